@@ rtl/gbpf_pkg.sv @@
package gbpf_pkg;

    localparam int DISPLAY_WIDTH_DEF    = 128;
    localparam int DISPLAY_HEIGHT_DEF   = 64;
    localparam int MAX_GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT          = 95;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;

    localparam logic [2:0] REQ_LOAD_ROW   = 3'd0;
    localparam logic [2:0] REQ_LOAD_WIDTH = 3'd1;
    localparam logic [2:0] REQ_SET_CURSOR = 3'd2;
    localparam logic [2:0] REQ_CHAR       = 3'd3;
    localparam logic [2:0] REQ_PIXEL      = 3'd4;
    localparam logic [2:0] REQ_FILL       = 3'd5;
    localparam logic [2:0] REQ_READ       = 3'd6;

    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_FIXED_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_PROP_MODE    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOPRINT  = 2'd1;
    localparam logic [1:0] ST_NOROOM   = 2'd2;

endpackage

@@ rtl/glyph_blitter_page_framebuffer.sv @@
// Page-organized monochrome framebuffer with a text renderer. One request is taken
// when start is high and busy is low; exactly one result follows, shown for one
// cycle with o_done high. The receiver cannot stall, so results are never held back.
// Load row, load width, set cursor, unused codes and an unprintable character go
// straight to the result. Read byte and pixel: the address is registered, the frame
// memory is read, then the byte is written back or captured. A character refused for
// lack of room, or one with zero width or zero height, ends after the width check.
// A drawn character reads each glyph row from the glyph memory and waits for it,
// then every column does a frame-byte read and write-back on the single
// frame-memory port. Fill sweeps the whole frame one byte per cycle. After reset
// the frame memory is cleared by the same sweep while busy stays high.
// o_cfg_ready is always high; write the registers only while no request is in flight.
module glyph_blitter_page_framebuffer #(
    parameter int DISPLAY_WIDTH    = gbpf_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT   = gbpf_pkg::DISPLAY_HEIGHT_DEF,
    parameter int MAX_GLYPH_HEIGHT = gbpf_pkg::MAX_GLYPH_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic [2:0]  i_req_type,
    input  logic [10:0] i_table_index,
    input  logic [15:0] i_row_value,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_x_pos,
    input  logic [7:0]  i_y_pos,
    input  logic        i_color,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_echoed_char,
    output logic [7:0]  o_frame_byte,
    output logic [7:0]  o_cursor_x,
    output logic [7:0]  o_cursor_y
);
    import gbpf_pkg::*;

    localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int FAW         = $clog2(FRAME_BYTES);
    localparam int ROW_DEPTH   = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int RAW         = $clog2(ROW_DEPTH);
    localparam int XW          = $clog2(DISPLAY_WIDTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_PIXWR  = 4'd3;
    localparam logic [3:0] S_ROWRD  = 4'd4;
    localparam logic [3:0] S_ROWWT  = 4'd5;
    localparam logic [3:0] S_COLRD  = 4'd6;
    localparam logic [3:0] S_COLWR  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_CHKRD  = 4'd9;

    // memories
    logic [7:0]  r_frame [FRAME_BYTES];
    logic [15:0] r_glyph [ROW_DEPTH];
    logic [4:0]  r_width [GLYPH_COUNT];

    logic [3:0]      r_state;
    logic [FAW-1:0]  r_faddr;
    logic [7:0]      r_fq;
    logic [15:0]     r_gq;
    logic [4:0]      r_wq;
    logic [7:0]      r_cx, r_cy;
    logic [4:0]      r_gh, r_fw;
    logic            r_pm;
    logic            r_color, r_fillv;
    logic [7:0]      r_code;
    logic [2:0]      r_req;
    logic [7:0]      r_py;
    logic            r_pix_ok, r_rd_ok;
    logic [4:0]      r_w, r_h;
    logic [4:0]      r_i, r_j;
    logic [15:0]     r_row;
    logic [RAW-1:0]  r_gbase;
    logic [6:0]      r_g;

    logic        fwe;
    logic [7:0]  fwd;
    logic [FAW-1:0] fra;
    logic        accept;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // saturated height, printable check
    logic [4:0] h_sat;
    logic       printable;
    logic [6:0] g_idx;
    assign h_sat     = (r_gh > 5'(MAX_GLYPH_HEIGHT)) ? 5'(MAX_GLYPH_HEIGHT) : r_gh;
    assign printable = (i_char_code >= FIRST_CODE) && (i_char_code <= LAST_CODE);
    assign g_idx     = 7'(i_char_code - FIRST_CODE);

    // column and row of the pixel being drawn
    logic [8:0] px_x, px_y;
    logic       lit, pv;
    assign px_x = 9'(r_cx) + 9'(r_j);
    assign px_y = 9'(r_cy) + 9'(r_i);
    assign lit  = (r_j < 5'd16) ? r_row[4'd15 - r_j[3:0]] : 1'b0;
    assign pv   = lit ? r_color : !r_color;

    function automatic logic [FAW-1:0] byte_addr(input logic [8:0] x, input logic [8:0] y);
        logic [FAW+8:0] a;
        a = FAW'(x[XW-1:0]) + FAW'(y[8:3]) * FAW'(DISPLAY_WIDTH);
        return a[FAW-1:0];
    endfunction

    function automatic logic [7:0] set_bit(input logic [7:0] b, input logic [2:0] k,
                                           input logic v);
        logic [7:0] r;
        r    = b;
        r[k] = v;
        return r;
    endfunction

    // frame memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (fwe) r_frame[r_faddr] <= fwd;
        r_fq <= r_frame[fra];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == REQ_LOAD_ROW && 32'(i_table_index) < ROW_DEPTH)
            r_glyph[i_table_index[RAW-1:0]] <= i_row_value;
        if (accept && i_req_type == REQ_LOAD_WIDTH && 32'(i_table_index) < GLYPH_COUNT)
            r_width[i_table_index[6:0]] <= i_row_value[4:0];
        r_gq <= r_glyph[r_gbase];
        r_wq <= r_width[g_idx];
    end

    always_comb begin
        fwe = 1'b0;
        fwd = r_fq;
        fra = r_faddr;
        case (r_state)
            S_CLEAR:  begin fwe = 1'b1; fwd = {8{r_fillv}}; end
            S_PIXWR:  begin
                fwe = r_pix_ok && (r_req == REQ_PIXEL);
                fwd = set_bit(r_fq, r_py[2:0], r_color);
            end
            S_COLRD:  fra = byte_addr(px_x, px_y);
            S_COLWR:  begin fwe = 1'b1; fwd = set_bit(r_fq, px_y[2:0], pv); end
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_faddr <= '0;
            r_fillv <= 1'b0;
            r_cx <= '0; r_cy <= '0;
            r_gh <= 5'd8; r_fw <= 5'd8; r_pm <= 1'b0;
            o_done <= 1'b0;
            r_req <= REQ_READ;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GLYPH_HEIGHT: r_gh <= i_cfg_data;
                    CFG_FIXED_WIDTH:  r_fw <= i_cfg_data;
                    CFG_PROP_MODE:    r_pm <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (accept) begin
                    r_req   <= i_req_type;
                    r_color <= i_color;
                    r_code  <= i_char_code;
                    r_py    <= i_y_pos;
                    o_status <= ST_OK; o_echoed_char <= '0; o_frame_byte <= '0;
                    case (i_req_type)
                        REQ_SET_CURSOR: begin
                            r_cx <= i_x_pos; r_cy <= i_y_pos; r_state <= S_DONE;
                        end
                        REQ_PIXEL: begin
                            r_pix_ok <= (32'(i_x_pos) < DISPLAY_WIDTH) &&
                                        (32'(i_y_pos) < DISPLAY_HEIGHT);
                            r_faddr  <= byte_addr({1'b0, i_x_pos}, {1'b0, i_y_pos});
                            r_state  <= S_RDWAIT;
                        end
                        REQ_READ: begin
                            r_rd_ok <= 32'(i_table_index) < FRAME_BYTES;
                            r_faddr <= i_table_index[FAW-1:0];
                            r_state <= S_RDWAIT;
                        end
                        REQ_FILL: begin
                            r_fillv <= i_color; r_faddr <= '0; r_state <= S_CLEAR;
                        end
                        REQ_CHAR: begin
                            r_g <= g_idx;
                            r_h <= h_sat;
                            if (!printable) begin
                                o_status <= ST_NOPRINT; r_state <= S_DONE;
                            end else
                                r_state <= S_CHKRD;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CLEAR: begin
                    r_faddr <= r_faddr + 1'b1;
                    if (32'(r_faddr) == FRAME_BYTES - 1) begin
                        if (r_req == REQ_FILL) r_state <= S_DONE;
                        else r_state <= S_IDLE;
                    end
                end
                // frame read issued at this edge, data lands for S_PIXWR
                S_RDWAIT: r_state <= S_PIXWR;
                S_PIXWR: begin
                    if (r_req == REQ_READ)
                        o_frame_byte <= r_rd_ok ? r_fq : 8'd0;
                    r_state <= S_DONE;
                end
                S_CHKRD: begin
                    // width table read has landed
                    r_w <= r_pm ? r_wq : r_fw;
                    if ((9'(r_cx) + 9'(r_pm ? r_wq : r_fw) > 9'(DISPLAY_WIDTH)) ||
                        (9'(r_cy) + 9'(r_h) > 9'(DISPLAY_HEIGHT))) begin
                        o_status <= ST_NOROOM; r_state <= S_DONE;
                    end else begin
                        r_gbase <= RAW'(r_g * r_h);
                        r_i <= '0;
                        r_state <= (r_h == 5'd0 || (r_pm ? r_wq : r_fw) == 5'd0)
                                   ? S_DONE : S_ROWRD;
                        o_echoed_char <= r_code;
                        if (r_h == 5'd0 || (r_pm ? r_wq : r_fw) == 5'd0)
                            r_cx <= r_cx + 8'(r_pm ? r_wq : r_fw);
                    end
                end
                S_ROWRD: r_state <= S_ROWWT;
                S_ROWWT: begin
                    r_row <= r_gq; r_j <= '0; r_state <= S_COLRD;
                end
                S_COLRD: r_state <= S_COLWR;
                S_COLWR: begin
                    if (r_j == r_w - 5'd1) begin
                        r_j <= '0;
                        if (r_i == r_h - 5'd1) begin
                            r_cx <= r_cx + 8'(r_w);
                            r_state <= S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_gbase <= r_gbase + 1'b1;
                            r_state <= S_ROWRD;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_COLRD;
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_COLWR || r_state == S_COLRD) r_faddr <= byte_addr(px_x, px_y);
        end
    end

    assign o_cursor_x = r_cx;
    assign o_cursor_y = r_cy;

    // a result strobe is never back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done twice");
    // once a request is taken, the block is busy
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accept not busy");
    // refused draws echo no character
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_echoed_char == 8'd0) else $error("echo");
endmodule
